[sv/i2cq_pkg.sv]
package i2cq_pkg;

	// Bus commands issued per step
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_SEND   = 3'd2,
		CMD_RSTART = 3'd3,
		CMD_RCEN   = 3'd4,
		CMD_ACK    = 3'd5,
		CMD_STOP   = 3'd6
	} cmd_t;

	// Item kinds
	typedef enum logic {
		OP_ENQUEUE   = 1'b0,
		OP_BUS_EVENT = 1'b1
	} op_t;

	// Transfer sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_DEV    = 4'd1,
		PH_REG_HI = 4'd2,
		PH_REG_LO = 4'd3,
		PH_DATA   = 4'd4,
		PH_RD_DEV = 4'd5,
		PH_RCEN   = 4'd6,
		PH_ACK    = 4'd7,
		PH_STOP   = 4'd8
	} phase_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_FETCH = 2'd1,
		ST_EXEC  = 2'd2
	} ctrl_state_t;

	localparam logic [7:0] DEV_MASK = 8'hFE;
	localparam logic [7:0] DEV_READ = 8'h01;

	// One queued transfer, 59 bits
	typedef struct packed {
		logic        rd;
		logic        wide;
		logic [7:0]  dev;
		logic [15:0] reg_addr;
		logic [15:0] base;
		logic [15:0] len;
		logic        ntf;
	} desc_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic fetch;
		logic exec;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_stall;
	} dp_status_t;

endpackage

[sv/i2cq_ctrl.sv]
module i2cq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  i2cq_pkg::dp_status_t status,
	output i2cq_pkg::ctrl_cmd_t  cmd
);

	i2cq_pkg::ctrl_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands: take item, read head entry, commit step
	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.fetch   = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			i2cq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = i2cq_pkg::ST_FETCH;
				end
			end
			i2cq_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_nxt = i2cq_pkg::ST_EXEC;
			end
			i2cq_pkg::ST_EXEC: begin
				// hold until the result register is free
				if (!status.out_stall) begin
					cmd.exec  = 1'b1;
					state_nxt = i2cq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = i2cq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/i2cq_dpath.sv]
module i2cq_dpath #(
	parameter int QUEUE_DEPTH = 8,
	parameter int IW          = $clog2(QUEUE_DEPTH),
	parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2cq_pkg::ctrl_cmd_t   cmd,
	output i2cq_pkg::dp_status_t  status,
	input  logic                  operation,
	input  logic                  is_read,
	input  logic                  wide_address,
	input  logic [7:0]            device_address,
	input  logic [15:0]           register_address,
	input  logic [15:0]           buffer_base,
	input  logic [15:0]           transfer_length,
	input  logic                  want_notify,
	input  logic [7:0]            received_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic                  kick_event,
	output logic [2:0]            bus_command,
	output logic [7:0]            byte_value,
	output logic                  send_from_buffer,
	output logic [15:0]           buffer_address,
	output logic                  store_byte,
	output logic                  nack_bit,
	output logic                  notify,
	output logic                  busy_res,
	output logic [CW-1:0]         queued_count
);

	localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	// Captured item
	logic                  op_q;
	i2cq_pkg::desc_t       in_desc_q;
	logic [7:0]            rx_q;

	// Queue storage and control state
	i2cq_pkg::desc_t       mem [QUEUE_DEPTH];
	i2cq_pkg::desc_t       head_desc_q;
	logic [IW-1:0]         head_q, tail_q;
	logic [CW-1:0]         count_q;
	i2cq_pkg::phase_t      phase_q;
	logic [15:0]           pos_q;
	logic                  busy_q;

	// Step results
	logic                  enq_ok;
	logic                  head_adv;
	logic [CW-1:0]         count_nxt;
	i2cq_pkg::phase_t      phase_nxt;
	logic [15:0]           pos_nxt;
	logic                  busy_nxt;
	logic                  r_acc, r_kick, r_sfb, r_store, r_nack, r_ntf;
	i2cq_pkg::cmd_t        r_cmd;
	logic [7:0]            r_bval;
	logic [15:0]           r_baddr;
	logic [15:0]           len_eff;
	logic [15:0]           pos_inc;
	logic [15:0]           base_sum;
	logic                  last_byte;

	// Output register
	logic                  out_valid_q;
	logic                  acc_q, kick_q, sfb_q, store_q, nack_q, ntf_q, busy_res_q;
	i2cq_pkg::cmd_t        cmd_q;
	logic [7:0]            bval_q;
	logic [15:0]           baddr_q;
	logic [CW-1:0]         qcnt_q;

	assign status.out_stall = out_valid_q && !out_ready;

	// Capture the incoming item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q               <= operation;
			in_desc_q.rd       <= is_read;
			in_desc_q.wide     <= wide_address;
			in_desc_q.dev      <= device_address & i2cq_pkg::DEV_MASK;
			in_desc_q.reg_addr <= register_address;
			in_desc_q.base     <= buffer_base;
			in_desc_q.len      <= transfer_length;
			in_desc_q.ntf      <= want_notify;
			rx_q               <= received_byte;
		end
	end

	// Descriptor memory: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) begin
			mem[tail_q] <= in_desc_q;
		end
		if (cmd.fetch) begin
			head_desc_q <= mem[head_q];
		end
	end

	assign len_eff   = (head_desc_q.len == 16'd0) ? 16'd1 : head_desc_q.len;
	assign pos_inc   = pos_q + 16'd1;
	assign base_sum  = head_desc_q.base + pos_q;
	assign last_byte = pos_inc >= len_eff;

	// Step logic for both item kinds
	always_comb begin
		enq_ok    = 1'b0;
		head_adv  = 1'b0;
		count_nxt = count_q;
		phase_nxt = phase_q;
		pos_nxt   = pos_q;
		busy_nxt  = busy_q;
		r_acc     = 1'b0;
		r_kick    = 1'b0;
		r_cmd     = i2cq_pkg::CMD_NONE;
		r_bval    = 8'd0;
		r_sfb     = 1'b0;
		r_baddr   = 16'd0;
		r_store   = 1'b0;
		r_nack    = 1'b0;
		r_ntf     = 1'b0;
		if (op_q == i2cq_pkg::OP_ENQUEUE) begin
			// store unless full; kick when the bus is idle
			if (count_q < FULL_CNT) begin
				enq_ok    = 1'b1;
				count_nxt = count_q + CW'(1);
				r_acc     = 1'b1;
				r_kick    = !busy_q;
			end
		end else if (count_q == '0) begin
			busy_nxt = 1'b0;
		end else begin
			busy_nxt = 1'b1;
			case (phase_q)
				i2cq_pkg::PH_IDLE: begin
					r_cmd     = i2cq_pkg::CMD_START;
					phase_nxt = i2cq_pkg::PH_DEV;
				end
				i2cq_pkg::PH_DEV: begin
					r_cmd     = i2cq_pkg::CMD_SEND;
					r_bval    = head_desc_q.dev;
					phase_nxt = head_desc_q.wide ? i2cq_pkg::PH_REG_HI : i2cq_pkg::PH_REG_LO;
				end
				i2cq_pkg::PH_REG_HI: begin
					r_cmd     = i2cq_pkg::CMD_SEND;
					r_bval    = head_desc_q.reg_addr[15:8];
					phase_nxt = i2cq_pkg::PH_REG_LO;
				end
				i2cq_pkg::PH_REG_LO: begin
					r_cmd     = i2cq_pkg::CMD_SEND;
					r_bval    = head_desc_q.reg_addr[7:0];
					phase_nxt = i2cq_pkg::PH_DATA;
				end
				i2cq_pkg::PH_DATA: begin
					if (head_desc_q.rd) begin
						r_cmd     = i2cq_pkg::CMD_RSTART;
						phase_nxt = i2cq_pkg::PH_RD_DEV;
					end else begin
						// send data byte fetched from the buffer
						r_cmd   = i2cq_pkg::CMD_SEND;
						r_sfb   = 1'b1;
						r_baddr = base_sum;
						pos_nxt = pos_inc;
						if (last_byte) begin
							phase_nxt = i2cq_pkg::PH_RD_DEV;
							pos_nxt   = 16'd0;
							r_ntf     = head_desc_q.ntf;
						end
					end
				end
				default: begin
					if (head_desc_q.rd && phase_q == i2cq_pkg::PH_RD_DEV) begin
						r_cmd     = i2cq_pkg::CMD_SEND;
						r_bval    = head_desc_q.dev | i2cq_pkg::DEV_READ;
						phase_nxt = i2cq_pkg::PH_RCEN;
					end else if (head_desc_q.rd && phase_q == i2cq_pkg::PH_RCEN) begin
						r_cmd     = i2cq_pkg::CMD_RCEN;
						phase_nxt = i2cq_pkg::PH_ACK;
					end else if (head_desc_q.rd && phase_q == i2cq_pkg::PH_ACK) begin
						// store received byte, NACK the last one
						r_cmd     = i2cq_pkg::CMD_ACK;
						r_store   = 1'b1;
						r_bval    = rx_q;
						r_baddr   = base_sum;
						pos_nxt   = pos_inc;
						phase_nxt = i2cq_pkg::PH_RCEN;
						if (last_byte) begin
							r_nack    = 1'b1;
							phase_nxt = i2cq_pkg::PH_STOP;
							pos_nxt   = 16'd0;
							r_ntf     = head_desc_q.ntf;
						end
					end else begin
						// stop and retire the head transfer
						r_cmd     = i2cq_pkg::CMD_STOP;
						phase_nxt = i2cq_pkg::PH_IDLE;
						pos_nxt   = 16'd0;
						head_adv  = 1'b1;
						count_nxt = count_q - CW'(1);
					end
				end
			endcase
		end
	end

	// Queue pointers and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			phase_q <= i2cq_pkg::PH_IDLE;
			pos_q   <= 16'd0;
			busy_q  <= 1'b0;
		end else if (cmd.exec) begin
			if (enq_ok) begin
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + IW'(1);
			end
			if (head_adv) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
			end
			count_q <= count_nxt;
			phase_q <= phase_nxt;
			pos_q   <= pos_nxt;
			busy_q  <= busy_nxt;
		end
	end

	// Result valid: set on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			acc_q      <= r_acc;
			kick_q     <= r_kick;
			cmd_q      <= r_cmd;
			bval_q     <= r_bval;
			sfb_q      <= r_sfb;
			baddr_q    <= r_baddr;
			store_q    <= r_store;
			nack_q     <= r_nack;
			ntf_q      <= r_ntf;
			busy_res_q <= busy_nxt;
			qcnt_q     <= count_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = acc_q;
	assign kick_event       = kick_q;
	assign bus_command      = cmd_q;
	assign byte_value       = bval_q;
	assign send_from_buffer = sfb_q;
	assign buffer_address   = baddr_q;
	assign store_byte       = store_q;
	assign nack_bit         = nack_q;
	assign notify           = ntf_q;
	assign busy_res         = busy_res_q;
	assign queued_count     = qcnt_q;

endmodule

[sv/i2c_master_transfer_queue_unit.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_ready  | operation, is_read, wide_address, device_address,
//          |                      | register_address, buffer_base, transfer_length,
//          |                      | want_notify, received_byte
// output   | out_valid/out_ready  | accepted, kick_event, bus_command, byte_value,
//          |                      | send_from_buffer, buffer_address, store_byte,
//          |                      | nack_bit, notify, busy_res, queued_count
//
// Each item goes through capture, head-entry read from the descriptor
// memory (registered read port), then commit of the step into the result register.
// One item is in flight at a time; the next may be taken while a result waits.
// A stalled output holds the commit cycle until the result register frees up.
// Reset clears queue pointers, count, phase, position and the busy flag; the
// descriptor memory is not cleared, entries are used only after being written.
module i2c_master_transfer_queue_unit #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic                               is_read,
	input  logic                               wide_address,
	input  logic [7:0]                         device_address,
	input  logic [15:0]                        register_address,
	input  logic [15:0]                        buffer_base,
	input  logic [15:0]                        transfer_length,
	input  logic                               want_notify,
	input  logic [7:0]                         received_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               accepted,
	output logic                               kick_event,
	output logic [2:0]                         bus_command,
	output logic [7:0]                         byte_value,
	output logic                               send_from_buffer,
	output logic [15:0]                        buffer_address,
	output logic                               store_byte,
	output logic                               nack_bit,
	output logic                               notify,
	output logic                               busy_res,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queued_count
);

	i2cq_pkg::ctrl_cmd_t  cmd;
	i2cq_pkg::dp_status_t status;

	i2cq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	i2cq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.operation        (operation),
		.is_read          (is_read),
		.wide_address     (wide_address),
		.device_address   (device_address),
		.register_address (register_address),
		.buffer_base      (buffer_base),
		.transfer_length  (transfer_length),
		.want_notify      (want_notify),
		.received_byte    (received_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.accepted         (accepted),
		.kick_event       (kick_event),
		.bus_command      (bus_command),
		.byte_value       (byte_value),
		.send_from_buffer (send_from_buffer),
		.buffer_address   (buffer_address),
		.store_byte       (store_byte),
		.nack_bit         (nack_bit),
		.notify           (notify),
		.busy_res         (busy_res),
		.queued_count     (queued_count)
	);

endmodule
